// ===== sv/cbd_pkg.sv =====
`default_nettype none

package cbd_pkg;

    localparam int unsigned SIZE_BITS_DEF = 32;
    localparam int unsigned STATUS_W = 3;

    localparam logic [STATUS_W-1:0] ST_RUNNING   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DONE      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BADHEX    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TRUNCATED = 3'd4;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd5;

    typedef struct packed {
        logic                payload_valid;
        logic [7:0]          payload_byte;
        logic [STATUS_W-1:0] decode_status;
    } t_result;

endpackage

`default_nettype wire

// ===== sv/cbd_core.sv =====
`default_nettype none

module cbd_core
    import cbd_pkg::*;
#(
    parameter int unsigned SIZE_BITS = SIZE_BITS_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_accept,
    input  wire logic [7:0] i_in_byte,
    input  wire logic    i_end_of_body,
    output t_result      o_result
);

    typedef enum logic [1:0] {
        PH_SIZE,
        PH_DATA,
        PH_DONE
    } t_phase;

    localparam logic [7:0] LF = 8'h0a;

    t_phase                 r_phase, n_phase;
    logic [SIZE_BITS-1:0]   r_acc, n_acc;
    logic [SIZE_BITS-1:0]   r_rem, n_rem;
    logic                   r_has_digit, n_has_digit;
    logic                   r_any, n_any;
    logic [STATUS_W-1:0]    r_status, n_status;

    logic       hex_ok;
    logic [3:0] hex_val;
    logic       ovf;

    always_comb begin
        hex_ok  = 1'b1;
        hex_val = 4'd0;
        if (i_in_byte >= "0" && i_in_byte <= "9") begin
            hex_val = 4'(i_in_byte - 8'h30);
        end else if (i_in_byte >= "a" && i_in_byte <= "f") begin
            hex_val = 4'(i_in_byte - 8'h57);
        end else if (i_in_byte >= "A" && i_in_byte <= "F") begin
            hex_val = 4'(i_in_byte - 8'h37);
        end else begin
            hex_ok = 1'b0;
        end
    end

    // top nibble set means another digit cannot fit
    assign ovf = |r_acc[SIZE_BITS-1 -: 4];

    always_comb begin
        n_phase     = r_phase;
        n_acc       = r_acc;
        n_rem       = r_rem;
        n_has_digit = r_has_digit;
        n_any       = r_any;
        n_status    = r_status;
        o_result.payload_valid = 1'b0;
        o_result.payload_byte  = 8'd0;

        unique case (r_phase)
            PH_DATA: begin
                o_result.payload_valid = 1'b1;
                o_result.payload_byte  = i_in_byte;
                n_any = 1'b1;
                n_rem = r_rem - 1'b1;
                if (r_rem == SIZE_BITS'(1)) begin
                    n_phase = PH_SIZE;
                end
            end
            PH_SIZE: begin
                if (i_in_byte == LF) begin
                    if (r_has_digit) begin
                        if (r_acc == '0) begin
                            n_phase  = PH_DONE;
                            n_status = r_any ? ST_DONE : ST_EMPTY;
                        end else begin
                            n_rem   = r_acc;
                            n_phase = PH_DATA;
                        end
                        n_acc       = '0;
                        n_has_digit = 1'b0;
                    end
                end else if (!hex_ok) begin
                    n_phase  = PH_DONE;
                    n_status = ST_BADHEX;
                end else if (ovf) begin
                    n_phase  = PH_DONE;
                    n_status = ST_OVERFLOW;
                end else begin
                    n_acc       = {r_acc[SIZE_BITS-5:0], hex_val};
                    n_has_digit = 1'b1;
                end
            end
            default: begin
            end
        endcase

        if (i_end_of_body && n_phase != PH_DONE) begin
            if (n_phase == PH_DATA) begin
                n_status = ST_TRUNCATED;
            end else if (n_has_digit && n_acc != '0) begin
                n_status = ST_TRUNCATED;
            end else begin
                n_status = n_any ? ST_DONE : ST_EMPTY;
            end
            n_phase = PH_DONE;
        end

        o_result.decode_status = n_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SIZE;
            r_acc       <= '0;
            r_rem       <= '0;
            r_has_digit <= 1'b0;
            r_any       <= 1'b0;
            r_status    <= ST_RUNNING;
        end else if (i_accept) begin
            r_phase     <= n_phase;
            r_acc       <= n_acc;
            r_rem       <= n_rem;
            r_has_digit <= n_has_digit;
            r_any       <= n_any;
            r_status    <= n_status;
        end
    end

endmodule

`default_nettype wire

// ===== sv/cbd_skid.sv =====
`default_nettype none

module cbd_skid
    import cbd_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    output logic         o_stall,
    input  wire t_result i_data,
    output logic         o_valid,
    input  wire logic    i_stall,
    output t_result      o_data
);

    logic    r_out_valid, r_skid_valid;
    t_result r_out, r_skid;
    logic    take_in, take_out;

    assign o_stall  = r_skid_valid;
    assign take_in  = i_valid && !r_skid_valid;
    assign take_out = r_out_valid && !i_stall;
    assign o_valid  = r_out_valid;
    assign o_data   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_out_valid || take_out) begin
                r_out_valid  <= r_skid_valid || take_in;
                r_skid_valid <= 1'b0;
            end else if (take_in) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || take_out) begin
            r_out <= r_skid_valid ? r_skid : i_data;
        end
        if (take_in && r_out_valid && !take_out) begin
            r_skid <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== sv/chunked_body_decoder.sv =====
// channel | direction | handshake                | payload
// --------+-----------+--------------------------+-----------------------------------------
// in      | input     | i_in_valid / o_in_stall  | i_in_byte, i_end_of_body
// out     | output    | o_out_valid / i_out_stall| o_payload_valid, o_payload_byte,
//         |           |                          | o_decode_status
//
// One transaction in gives one transaction out, one byte per clock sustained unless
// stalled. Decode state and the result are both registered on the accepting edge,
// into the output entry or, under a stall, the skid entry. A two-entry output buffer
// absorbs a downstream stall; o_in_stall rises only once both entries hold results.
// Synchronous active-low reset returns to the size line phase, status running.
`default_nettype none

module chunked_body_decoder
    import cbd_pkg::*;
#(
    parameter int unsigned SIZE_BITS = SIZE_BITS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic [7:0]          i_in_byte,
    input  wire logic                i_end_of_body,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic                     o_payload_valid,
    output logic [7:0]               o_payload_byte,
    output logic [STATUS_W-1:0]      o_decode_status
);

    logic    accept;
    t_result core_res, out_res;

    assign accept = i_in_valid && !o_in_stall;

    cbd_core #(
        .SIZE_BITS(SIZE_BITS)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_in_byte     (i_in_byte),
        .i_end_of_body (i_end_of_body),
        .o_result      (core_res)
    );

    cbd_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_data  (core_res),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (out_res)
    );

    assign o_payload_valid = out_res.payload_valid;
    assign o_payload_byte  = out_res.payload_byte;
    assign o_decode_status = out_res.decode_status;

endmodule

`default_nettype wire
